### rtl/core/cap_pkg.sv
// ----------------------------------------------------------------------------
// cap_pkg: shared constants and tables for the phase angle pipeline
// Fixed widths, angle constants and the arctangent table in Q30.
// ----------------------------------------------------------------------------
package cap_pkg;

   localparam int IN_WIDTH_DEF = 16;
   localparam int STAGES_DEF   = 16;
   localparam int ATAN_ENTRIES = 30;
   localparam int GUARD_BITS   = 16;
   localparam int PHASE_WIDTH  = 16;
   localparam int ACC_WIDTH    = 34;
   localparam int ROUND_SHIFT  = 17;
   localparam int Q_WIDTH      = ACC_WIDTH - ROUND_SHIFT;

   localparam logic signed [ACC_WIDTH-1:0]   HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ACC_WIDTH-1:0]   ROUND_HALF  = 34'sd65536;
   localparam logic signed [Q_WIDTH-1:0]     PI_Q13_Q    = 17'sd25736;
   localparam logic signed [PHASE_WIDTH-1:0] PI_Q13      = 16'sd25736;

   typedef logic [4:0] atan_idx_type;

   // atan(2^-i) * 2^30, truncated
   function automatic logic [ACC_WIDTH-1:0] atan_q30(input atan_idx_type idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h3243F6A8;
         5'd1:    val = 32'h1DAC6705;
         5'd2:    val = 32'h0FADBAFC;
         5'd3:    val = 32'h07F56EA6;
         5'd4:    val = 32'h03FEAB76;
         5'd5:    val = 32'h01FFD55B;
         5'd6:    val = 32'h00FFFAAA;
         5'd7:    val = 32'h007FFF55;
         5'd8:    val = 32'h003FFFEA;
         5'd9:    val = 32'h001FFFFD;
         5'd10:   val = 32'h000FFFFF;
         5'd11:   val = 32'h0007FFFF;
         5'd12:   val = 32'h0003FFFF;
         5'd13:   val = 32'h0001FFFF;
         5'd14:   val = 32'h0000FFFF;
         5'd15:   val = 32'h00007FFF;
         5'd16:   val = 32'h00003FFF;
         5'd17:   val = 32'h00001FFF;
         5'd18:   val = 32'h00000FFF;
         5'd19:   val = 32'h000007FF;
         5'd20:   val = 32'h000003FF;
         5'd21:   val = 32'h000001FF;
         5'd22:   val = 32'h000000FF;
         5'd23:   val = 32'h0000007F;
         5'd24:   val = 32'h0000003F;
         5'd25:   val = 32'h0000001F;
         5'd26:   val = 32'h0000000F;
         5'd27:   val = 32'h00000007;
         5'd28:   val = 32'h00000003;
         5'd29:   val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return ACC_WIDTH'(val);
   endfunction

endpackage

### rtl/core/complex_phase_angle.sv
// ----------------------------------------------------------------------------
// complex_phase_angle: four-quadrant arctangent of a complex sample
// CORDIC vectoring pipeline giving the phase in radians, Q13 (pi = 25736).
// ----------------------------------------------------------------------------
// One request enters per clock while req_ready is high; its phase passes through
// one register for the sign extension and quarter-turn pre-rotation, one per
// CORDIC micro-rotation (STAGES of them), and one for rounding and clamping.
// Throughput is one request per clock; when rsp_ready is low the pipeline
// fills its empty slots before req_ready drops. Zero imaginary part is
// handled on the side: it gives +pi for a negative real part, else 0.
module complex_phase_angle #(
   parameter int IN_WIDTH = cap_pkg::IN_WIDTH_DEF,
   parameter int STAGES   = cap_pkg::STAGES_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [IN_WIDTH-1:0]                 req_real_part,
   input  logic signed [IN_WIDTH-1:0]                 req_imag_part,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [cap_pkg::PHASE_WIDTH-1:0]     rsp_phase
);
   import cap_pkg::*;

   // magnitude grows by about 1.65 over the micro-rotations, up to about 2.33 times the largest input part
   localparam int DW = IN_WIDTH + GUARD_BITS + 3;

   logic signed [DW-1:0]        x_ff   [0:STAGES];
   logic signed [DW-1:0]        y_ff   [0:STAGES];
   logic signed [ACC_WIDTH-1:0] acc_ff [0:STAGES];
   logic [STAGES:0]             yzero_ff;
   logic [STAGES:0]             xneg_ff;
   logic [STAGES:0]             valid_ff;
   logic [STAGES+1:0]           stage_rdy;

   logic                         out_valid_ff;
   logic signed [PHASE_WIDTH-1:0] phase_ff;

   // ready ripples back through empty slots
   always_comb begin
      stage_rdy[STAGES+1] = !out_valid_ff || rsp_ready;
      for (int k = STAGES; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
   end

   assign req_ready = stage_rdy[0];

   // stage 0: sign extend, pre-rotate the left half plane, add guard bits
   logic signed [DW-1:0]        re_ext, im_ext, x0_in, y0_in;
   logic signed [ACC_WIDTH-1:0] acc0_in;

   always_comb begin
      re_ext  = DW'(req_real_part);
      im_ext  = DW'(req_imag_part);
      x0_in   = re_ext;
      y0_in   = im_ext;
      acc0_in = '0;
      if (re_ext < 0) begin
         if (im_ext >= 0) begin
            x0_in   = im_ext;
            y0_in   = -re_ext;
            acc0_in = HALF_PI_Q30;
         end else begin
            x0_in   = -im_ext;
            y0_in   = re_ext;
            acc0_in = -HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (stage_rdy[0]) begin
         valid_ff[0] <= req_valid;
      end
      if (stage_rdy[0]) begin
         x_ff[0]     <= x0_in <<< GUARD_BITS;
         y_ff[0]     <= y0_in <<< GUARD_BITS;
         acc_ff[0]   <= acc0_in;
         yzero_ff[0] <= (req_imag_part == '0);
         xneg_ff[0]  <= req_real_part[IN_WIDTH-1];
      end
   end

   // micro-rotation stages
   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      logic signed [DW-1:0]        xs, ys, x_in, y_in;
      logic signed [ACC_WIDTH-1:0] atan_val, acc_in;

      always_comb begin
         xs       = x_ff[i] >>> i;
         ys       = y_ff[i] >>> i;
         atan_val = $signed(atan_q30(atan_idx_type'(i)));
         if (!y_ff[i][DW-1]) begin
            x_in   = x_ff[i] + ys;
            y_in   = y_ff[i] - xs;
            acc_in = acc_ff[i] + atan_val;
         end else begin
            x_in   = x_ff[i] - ys;
            y_in   = y_ff[i] + xs;
            acc_in = acc_ff[i] - atan_val;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (stage_rdy[i+1]) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (stage_rdy[i+1]) begin
            x_ff[i+1]     <= x_in;
            y_ff[i+1]     <= y_in;
            acc_ff[i+1]   <= acc_in;
            yzero_ff[i+1] <= yzero_ff[i];
            xneg_ff[i+1]  <= xneg_ff[i];
         end
      end
   end

   // round half up to Q13, clamp to +-pi, patch the real axis
   logic signed [ACC_WIDTH-1:0]   rnd_sum;
   logic signed [Q_WIDTH-1:0]     q_val;
   logic signed [PHASE_WIDTH-1:0] phase_in;

   always_comb begin
      rnd_sum = acc_ff[STAGES] + ROUND_HALF;
      q_val   = rnd_sum[ACC_WIDTH-1:ROUND_SHIFT];
      if (q_val > PI_Q13_Q) begin
         phase_in = PI_Q13;
      end else if (q_val < -PI_Q13_Q) begin
         phase_in = -PI_Q13;
      end else begin
         phase_in = q_val[PHASE_WIDTH-1:0];
      end
      if (yzero_ff[STAGES]) begin
         phase_in = xneg_ff[STAGES] ? PI_Q13 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_rdy[STAGES+1]) begin
         out_valid_ff <= valid_ff[STAGES];
      end
      if (stage_rdy[STAGES+1]) begin
         phase_ff <= phase_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_phase = phase_ff;

endmodule
